// ----- rtl/box_filter_downsample_2x2_assert.svh -----
// assertion macros used by the downsampler top level
// no dependencies; the top level includes this header to check behavior
`ifndef BOX_FILTER_DOWNSAMPLE_2X2_ASSERT_SVH
`define BOX_FILTER_DOWNSAMPLE_2X2_ASSERT_SVH
`ifndef SYNTH
// condition in the same cycle implies consequence
`define BFD_ASSERT_IMPL(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("bfd assertion failed");
// condition implies consequence in the next cycle
`define BFD_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("bfd assertion failed");
`else
`define BFD_ASSERT_IMPL(label, clk_i, rstn_i, ante, cons)
`define BFD_ASSERT_NEXT(label, clk_i, rstn_i, ante, cons)
`endif
`endif

// ----- rtl/bfd_pkg.sv -----
// shared types and constants of the 2x2 box filter downsampler
// no dependencies
`timescale 1ns / 1ps

package bfd_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = 17;
  localparam int WIDTH_W       = 13;
  localparam int HEIGHT_W      = 16;
  localparam int CFG_W         = 16;
  localparam int MAX_WIDTH_DEF = 4096;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 13'd4096;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd4096;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_SOURCE_WIDTH  = 1'b0,
    REG_SOURCE_HEIGHT = 1'b1
  } bfd_reg_t;

  // decoded request handed from the scan stage to the averaging stage
  typedef struct packed {
    logic             emit;       // request produces an output pixel
    logic             use_store;  // add the stored pair sum of the even row
    logic [1:0]       shift;      // divide by 1, 2 or 4
    logic             last;       // final output pixel of the frame
    logic [SUM_W-1:0] pair;       // horizontal pair sum of this row
  } bfd_pix_t;

endpackage

// ----- rtl/bfd_scan.sv -----
// scan position tracking, configuration registers and per-request decode
// depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_scan #(
  parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF,
  parameter int AW        = 11
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]   cfg_data,
  input  logic                        in_accept,
  input  logic [bfd_pkg::SAMPLE_W-1:0] sample,
  output bfd_pkg::bfd_pix_t           pix,
  output logic                        store_we,
  output logic                        store_re,
  output logic [AW-1:0]               store_addr
);
  import bfd_pkg::*;

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > WIDTH_W) ? CW + 1 : WIDTH_W;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

  logic [WIDTH_W-1:0]  source_width_r;
  logic [HEIGHT_W-1:0] source_height_r;
  logic [CW-1:0]       col_r, col_nxt;
  logic [HEIGHT_W-1:0] row_r, row_nxt;
  logic [SUM_W-1:0]    pair_r;

  logic [EW-1:0]       w_eff, sw_ext, even_w, last_col, col_ext, col_inc;
  logic [HEIGHT_W-1:0] h_eff, even_h, last_row, row_c;
  logic [CW-1:0]       col_c;
  logic [HEIGHT_W:0]   row_inc;
  logic                w_one, h_one, hdone, wr_cond;
  logic [SUM_W-1:0]    pair_new;

  // effective frame size
  always_comb begin
    sw_ext = EW'(source_width_r);
    if (sw_ext == '0) begin
      w_eff = EW'(1);
    end else if (sw_ext > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = sw_ext;
    end
    h_eff    = (source_height_r == '0) ? HEIGHT_W'(1) : source_height_r;
    w_one    = (w_eff == EW'(1));
    h_one    = (h_eff == HEIGHT_W'(1));
    even_w   = {w_eff[EW-1:1], 1'b0};
    even_h   = {h_eff[HEIGHT_W-1:1], 1'b0};
    last_col = w_one ? '0 : even_w - EW'(1);
    last_row = h_one ? '0 : even_h - HEIGHT_W'(1);
  end

  // position of this request, pair sum and output decode
  always_comb begin
    if ((EW'(col_r) >= w_eff) || (row_r >= h_eff)) begin
      col_c = '0;
      row_c = '0;
    end else begin
      col_c = col_r;
      row_c = row_r;
    end
    col_ext = EW'(col_c);

    if (w_one || !col_c[0]) begin
      pair_new = SUM_W'(sample);
    end else begin
      pair_new = pair_r + SUM_W'(sample);
    end

    if (w_one) begin
      hdone = 1'b1;
    end else if (!col_c[0]) begin
      hdone = 1'b0;
    end else begin
      hdone = (col_ext < even_w);
    end

    pix.pair      = pair_new;
    pix.use_store = !h_one;
    pix.emit      = hdone && (h_one || row_c[0]);
    pix.last      = (col_ext == last_col) && (row_c == last_row);
    if (h_one) begin
      pix.shift = w_one ? 2'd0 : 2'd1;
    end else begin
      pix.shift = w_one ? 2'd1 : 2'd2;
    end

    wr_cond    = hdone && !h_one && !row_c[0] && (row_c < even_h);
    store_we   = in_accept && wr_cond;
    store_re   = in_accept && hdone && !h_one && row_c[0];
    store_addr = AW'(col_c >> 1);
  end

  // advance along the row, wrap to the next row and the next frame
  always_comb begin
    col_inc = col_ext + EW'(1);
    row_inc = {1'b0, row_c} + (HEIGHT_W + 1)'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_W-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = row_c;
    end
  end

  // configuration registers and scan state; a register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_width_r  <= WIDTH_RST;
      source_height_r <= HEIGHT_RST;
      col_r           <= '0;
      row_r           <= '0;
      pair_r          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SOURCE_WIDTH:  source_width_r  <= cfg_data[WIDTH_W-1:0];
        REG_SOURCE_HEIGHT: source_height_r <= cfg_data[HEIGHT_W-1:0];
      endcase
      col_r  <= '0;
      row_r  <= '0;
      pair_r <= '0;
    end else if (in_accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pair_r <= pair_new;
    end
  end

endmodule

// ----- rtl/bfd_line_store.sv -----
// line store holding the horizontal pair sums of the last even row
// depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_line_store #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [AW-1:0]            addr,
  input  logic [bfd_pkg::SUM_W-1:0] wdata,
  output logic [bfd_pkg::SUM_W-1:0] rdata
);
  import bfd_pkg::*;

  logic [SUM_W-1:0] mem [DEPTH];
  logic [SUM_W-1:0] rdata_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/bfd_average.sv -----
// decode register, vertical sum and divide, output register with stall
// depends on bfd_pkg
`timescale 1ns / 1ps

module bfd_average (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_accept,
  input  bfd_pkg::bfd_pix_t            pix,
  input  logic [bfd_pkg::SUM_W-1:0]    store_rdata,
  output logic                         in_stall,
  output logic                         s1_busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfd_pkg::SAMPLE_W-1:0] out_averaged_sample,
  output logic                         out_frame_last
);
  import bfd_pkg::*;

  logic                s1_valid_r;
  bfd_pix_t            s1_r;
  logic                out_valid_r;
  logic [SAMPLE_W-1:0] avg_r, avg_nxt;
  logic                last_r;
  logic                s1_adv;
  logic [SUM_W:0]      total;

  // the decode stage moves on when the output register is free or being taken
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign s1_busy  = s1_valid_r;

  // add the stored even-row pair sum and divide by the sample count
  always_comb begin
    total   = {1'b0, s1_r.pair} + (s1_r.use_store ? {1'b0, store_rdata} : '0);
    avg_nxt = SAMPLE_W'(total >> s1_r.shift);
  end

  // control of both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= pix.emit;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // payload of both stages
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_r <= pix;
    end
    if (s1_adv) begin
      avg_r  <= avg_nxt;
      last_r <= s1_r.last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_averaged_sample = avg_r;
  assign out_frame_last      = last_r;

endmodule

// ----- rtl/box_filter_downsample_2x2.sv -----
// top level of the 2x2 box filter downsampler
// depends on bfd_pkg, bfd_scan, bfd_line_store, bfd_average and the assertion header
//
// Usage:
//   Source samples enter on in_valid / in_stall / in_height_sample in raster
//   order; a request is taken at a clock edge with in_valid high and in_stall
//   low. Each sample that completes a 2x2 block (or a 2- or 1-sample block
//   when a dimension is one) yields one result on out_valid / out_stall with
//   the floor average and out_frame_last set on the final pixel of a frame.
//   Odd last columns and rows are consumed without a result.
//   Each result passes the decode register and then the output register.
//   Throughput: one sample per clock while in_stall is low; the line store
//   does one write or one read per cycle.
//   cfg_we writes source_width (index 0) or source_height (index 1) from
//   cfg_data and restarts the frame; write only while the block is idle.
//   Reset (rst_n low, synchronous) empties the pipeline, restores both sizes
//   to 4096 and starts a new frame; the line store needs no clearing.
//   While out_stall holds a result, one more result waits in the decode stage
//   and in_stall rises only when both are full.
`timescale 1ns / 1ps
`include "box_filter_downsample_2x2_assert.svh"

module box_filter_downsample_2x2 #(
  parameter int MAX_WIDTH = bfd_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [bfd_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [bfd_pkg::SAMPLE_W-1:0] in_height_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bfd_pkg::SAMPLE_W-1:0] out_averaged_sample,
  output logic                         out_frame_last
);
  import bfd_pkg::*;

  localparam int DEPTH = (MAX_WIDTH / 2 > 1) ? MAX_WIDTH / 2 : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic             in_accept;
  bfd_pix_t         pix;
  logic             store_we, store_re;
  logic [AW-1:0]    store_addr;
  logic [SUM_W-1:0] store_rdata;
  logic             s1_busy;

  assign in_accept = in_valid && !in_stall;

  // scan position, registers and request decode
  bfd_scan #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .sample     (in_height_sample),
    .pix        (pix),
    .store_we   (store_we),
    .store_re   (store_re),
    .store_addr (store_addr)
  );

  // even-row pair sums
  bfd_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_line_store (
    .clk   (clk),
    .we    (store_we),
    .re    (store_re),
    .addr  (store_addr),
    .wdata (pix.pair),
    .rdata (store_rdata)
  );

  // averaging and output register
  bfd_average u_average (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_accept           (in_accept),
    .pix                 (pix),
    .store_rdata         (store_rdata),
    .in_stall            (in_stall),
    .s1_busy             (s1_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_averaged_sample (out_averaged_sample),
    .out_frame_last      (out_frame_last)
  );

  // input stalls only when both result stages are occupied
  `BFD_ASSERT_IMPL(a_stall_only_when_full, clk, rst_n, in_stall, out_valid && s1_busy)
  // the line store never writes and reads in the same cycle
  `BFD_ASSERT_IMPL(a_store_single_op, clk, rst_n, store_we, !store_re)
  // an accepted request that completes a block occupies the decode stage
  `BFD_ASSERT_NEXT(a_emit_enters_stage, clk, rst_n, in_accept && pix.emit, s1_busy)

endmodule
